/* hdl/cwsbs_pkg.sv */
// Package for the code word strobe/busy sender.
// Holds the transfer payload types, phase and kind codes, and register indexes.
// No dependencies.
package cwsbs_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WAIT_LO = 3'd1,
		PH_SETTLE  = 3'd2,
		PH_WAIT_HI = 3'd3,
		PH_DELAY   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_WORD = 2'd0,
		KIND_BUSY = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	localparam logic [1:0] CFG_KEYBOARD_MODE    = 2'd0;
	localparam logic [1:0] CFG_AFTER_WORD_TICKS = 2'd1;

	localparam logic [1:0] END_MORE  = 2'd0;
	localparam logic [1:0] END_LAST  = 2'd1;
	localparam logic [1:0] END_OTHER = 2'd2;

	localparam logic [7:0] SEP_MORE = 8'hf0;
	localparam logic [7:0] SEP_LAST = 8'hff;

	localparam logic [7:0] TICKS_RESET = 8'd7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] code_word;
		logic [7:0]  separator;
		logic        busy_level;
	} item_t;

	typedef struct packed {
		logic [7:0] port_data;
		logic       strobe_level;
		logic       ready_res;
		logic       word_done;
		logic [1:0] end_status;
		logic       dropped;
	} result_t;

endpackage

/* hdl/code_word_strobe_busy_sender.sv */
// Path from item transfer to result: input register, then result register.
// One item per cycle unless res_stall holds; each item is a single state update.
// Reset (arst_n low, asynchronous): phase idle, strobe released, data zero,
// keyboard_mode 0, after_word_ticks 7, both pipeline registers empty.
// Top level of the code word strobe/busy sender; depends on cwsbs_pkg.
module code_word_strobe_busy_sender import cwsbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       res_valid,
	input  logic       res_stall,
	output result_t    res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic        keyboard_mode_q;
	logic [7:0]  after_word_ticks_q;

	phase_t      phase_q, phase_d;
	logic [1:0]  byte_index_q, byte_index_d;
	logic [31:0] word_hold_q, word_hold_d;
	logic [7:0]  delay_count_q, delay_count_d;
	logic [1:0]  end_class_q, end_class_d;
	logic [7:0]  data_out_q, data_out_d;
	logic        strobe_q, strobe_d;

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	logic        step;
	result_t     res_d;

	logic [30:0] low_bits;
	logic [31:0] ruled_word;
	logic [7:0]  delay_dec;

	assign cfg_ready  = 1'b1;
	assign advance    = !res_valid || !res_stall;
	assign item_stall = valid_s1 && !advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyboard_mode_q    <= 1'b0;
			after_word_ticks_q <= TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEYBOARD_MODE:    keyboard_mode_q    <= cfg_data[0];
				CFG_AFTER_WORD_TICKS: after_word_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// fewer than two of the low 31 bits set: zero or a power of two
	assign low_bits   = item_s1.code_word[30:0];
	assign ruled_word = !keyboard_mode_q ? {1'b0, low_bits} :
		{item_s1.code_word[31] | ((low_bits & (low_bits - 31'd1)) == 31'd0), low_bits};
	assign delay_dec  = (delay_count_q != 8'd0) ? delay_count_q - 8'd1 : delay_count_q;

	always_comb begin
		phase_d       = phase_q;
		byte_index_d  = byte_index_q;
		word_hold_d   = word_hold_q;
		delay_count_d = delay_count_q;
		end_class_d   = end_class_q;
		data_out_d    = data_out_q;
		strobe_d      = strobe_q;
		res_d         = '0;
		case (item_s1.kind)
			KIND_WORD: begin
				if (phase_q == PH_IDLE) begin
					word_hold_d  = ruled_word;
					byte_index_d = 2'd0;
					phase_d      = PH_WAIT_LO;
					if (item_s1.separator == SEP_MORE) begin
						end_class_d = END_MORE;
					end else if (item_s1.separator == SEP_LAST) begin
						end_class_d = END_LAST;
					end else begin
						end_class_d = END_OTHER;
					end
				end else begin
					res_d.dropped = 1'b1;
				end
			end
			KIND_BUSY: begin
				case (phase_q)
					PH_WAIT_LO: begin
						if (!item_s1.busy_level) begin
							data_out_d = word_hold_q[{~byte_index_q, 3'b000} +: 8];
							phase_d    = PH_SETTLE;
						end
					end
					PH_SETTLE: begin
						if (!item_s1.busy_level) begin
							strobe_d = 1'b1;
							phase_d  = PH_WAIT_HI;
						end
					end
					PH_WAIT_HI: begin
						if (item_s1.busy_level) begin
							strobe_d = 1'b0;
							if (byte_index_q == 2'd3) begin
								byte_index_d = 2'd0;
								if (keyboard_mode_q && after_word_ticks_q != 8'd0) begin
									delay_count_d = after_word_ticks_q;
									phase_d       = PH_DELAY;
								end else begin
									res_d.word_done = 1'b1;
									phase_d         = PH_IDLE;
								end
							end else begin
								byte_index_d = byte_index_q + 2'd1;
								phase_d      = PH_WAIT_LO;
							end
						end
					end
					default: ;
				endcase
			end
			KIND_TICK: begin
				if (phase_q == PH_DELAY) begin
					delay_count_d = delay_dec;
					if (delay_dec == 8'd0) begin
						res_d.word_done = 1'b1;
						phase_d         = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
		res_d.port_data    = data_out_d;
		res_d.strobe_level = strobe_d;
		res_d.ready_res    = (phase_d == PH_IDLE);
		res_d.end_status   = end_class_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_index_q  <= 2'd0;
			word_hold_q   <= '0;
			delay_count_q <= '0;
			end_class_q   <= '0;
			data_out_q    <= '0;
			strobe_q      <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			byte_index_q  <= byte_index_d;
			word_hold_q   <= word_hold_d;
			delay_count_q <= delay_count_d;
			end_class_q   <= end_class_d;
			data_out_q    <= data_out_d;
			strobe_q      <= strobe_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res <= res_d;
		end
	end

	a_strobe_in_wait_hi: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> phase_q == PH_WAIT_HI)
		else $error("strobe asserted outside busy-high wait");

	a_delay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DELAY |-> delay_count_q != 8'd0)
		else $error("delay phase with zero count");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> byte_index_q == 2'd0 && !strobe_q)
		else $error("idle with byte index or strobe left over");

	a_done_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.word_done |-> res.ready_res && !res.dropped)
		else $error("word done without returning to idle");

	a_drop_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.dropped |-> !res.ready_res)
		else $error("code word dropped while idle");

endmodule
